FILE: hdl/slkf_pkg.sv
// ============================================================================
// slkf_pkg
// Types, constants and helper functions shared by the serial line keyword
// filter modules.
// ============================================================================
package slkf_pkg;

    localparam int DEFAULT_LINE_DEPTH = 100;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_FILTER_ENABLE  = 2'd0;
    localparam logic [1:0] REG_ADDRESS_ENABLE = 2'd1;
    localparam logic [1:0] REG_TARGET_ADDRESS = 2'd2;

    localparam logic [15:0] TARGET_ADDRESS_RESET = 16'hFFFF;

    localparam logic MODE_RX   = 1'b0;
    localparam logic MODE_READ = 1'b1;

    localparam logic [7:0]  CH_CR         = 8'h0D;
    localparam logic [7:0]  CH_LF         = 8'h0A;
    localparam logic [7:0]  CH_FIRST_PRINT = 8'h20;
    localparam logic [7:0]  CH_LAST_PRINT  = 8'h7E;
    localparam logic [31:0] MARKER_WORD    = 32'h39393939;

    localparam logic [3:0] NIB_TEN = 4'd10;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_HEX_BASE = 8'h37;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
        logic [6:0] read_index;
    } req_item_t;

    typedef struct packed {
        logic       line_accepted;
        logic [6:0] line_length;
        logic [7:0] read_data;
    } rsp_item_t;

    typedef struct packed {
        logic        filter_enable;
        logic        address_filter_enable;
        logic [15:0] target_address;
    } cfg_t;

    typedef struct packed {
        logic       accepted;
        logic       hit;
        logic [6:0] length;
    } step_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < NIB_TEN)
        begin
            ch = CH_ZERO + {4'h0, nib};
        end
        else
        begin
            ch = CH_HEX_BASE + {4'h0, nib};
        end
        return ch;
    endfunction

    function automatic logic [31:0] address_word(input logic [15:0] addr);
        return {hex_char(addr[15:12]), hex_char(addr[11:8]),
                hex_char(addr[7:4]), hex_char(addr[3:0])};
    endfunction

endpackage

FILE: hdl/serial_line_keyword_filter.sv
// ============================================================================
// serial_line_keyword_filter
// Assembles received serial bytes into lines, filters them on a keyword and
// an address, and keeps the last accepted line for read back.
// ============================================================================
// One item is accepted every cycle unless the input stalls, and its result
// passes through the registered read of the byte memory and then the output
// register. Lines and the stored message share one memory of 2*LINE_DEPTH
// bytes split into two banks; accepting a line swaps the banks, so no copy
// takes place. A result left waiting under stall still lets one more item in
// before the input stalls.
// ============================================================================
module serial_line_keyword_filter
    import slkf_pkg::*;
#(
    parameter int LINE_DEPTH = DEFAULT_LINE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_item_t             req,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_item_t             rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int ADDR_W = $clog2(2 * LINE_DEPTH);

    cfg_t              cfg;
    step_t             step;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    logic              req_accept;
    logic              o_ready;
    logic              p_go;
    logic              p_valid_reg;
    logic              p_valid_next;
    step_t             p_step_reg;
    logic              o_valid_reg;
    logic              o_valid_next;
    rsp_item_t         o_item_reg;

    slkf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    slkf_line #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_line (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (req_accept),
        .item    (req),
        .cfg     (cfg),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .step    (step)
    );

    slkf_buffer #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_buffer (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign o_ready    = !o_valid_reg || !rsp_stall;
    assign p_go       = p_valid_reg && o_ready;
    assign req_stall  = p_valid_reg && !o_ready;
    assign req_accept = req_valid && !req_stall;

    always_comb
    begin
        p_valid_next = p_valid_reg;
        if (req_accept)
        begin
            p_valid_next = 1'b1;
        end
        else if (p_go)
        begin
            p_valid_next = 1'b0;
        end
        o_valid_next = o_valid_reg;
        if (p_go)
        begin
            o_valid_next = 1'b1;
        end
        else if (o_valid_reg && !rsp_stall)
        begin
            o_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= p_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            p_step_reg <= step;
        end
        if (p_go)
        begin
            o_item_reg.line_accepted <= p_step_reg.accepted;
            o_item_reg.line_length   <= p_step_reg.length;
            o_item_reg.read_data     <= p_step_reg.hit ? rd_data : 8'd0;
        end
    end

    assign rsp_valid = o_valid_reg;
    assign rsp       = o_item_reg;

endmodule

FILE: hdl/slkf_regs.sv
// ============================================================================
// slkf_regs
// APB configuration registers: filter enable, address filter enable and
// target address.
// ============================================================================
module slkf_regs
    import slkf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[3:2])
                REG_FILTER_ENABLE:  cfg_next.filter_enable = pwdata[0];
                REG_ADDRESS_ENABLE: cfg_next.address_filter_enable = pwdata[0];
                REG_TARGET_ADDRESS: cfg_next.target_address = pwdata[15:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_FILTER_ENABLE:  prdata = {31'd0, cfg_reg.filter_enable};
            REG_ADDRESS_ENABLE: prdata = {31'd0, cfg_reg.address_filter_enable};
            REG_TARGET_ADDRESS: prdata = {16'd0, cfg_reg.target_address};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_enable         <= 1'b0;
            cfg_reg.address_filter_enable <= 1'b0;
            cfg_reg.target_address        <= TARGET_ADDRESS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/slkf_buffer.sv
// ============================================================================
// slkf_buffer
// Byte memory holding two banks: the line being received and the stored
// message. One write port and one registered read port.
// ============================================================================
module slkf_buffer
    import slkf_pkg::*;
#(
    parameter int LINE_DEPTH = DEFAULT_LINE_DEPTH,
    localparam int ADDR_W = $clog2(2 * LINE_DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [2 * LINE_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/slkf_line.sv
// ============================================================================
// slkf_line
// Line assembly and keyword matching. Tracks the fill pointer, the sliding
// window of recent characters, the match flags, the message length and which
// memory bank holds the line being received.
// ============================================================================
module slkf_line
    import slkf_pkg::*;
#(
    parameter int LINE_DEPTH = DEFAULT_LINE_DEPTH,
    localparam int ADDR_W = $clog2(2 * LINE_DEPTH),
    localparam int PTR_W  = $clog2(LINE_DEPTH)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  req_item_t         item,
    input  cfg_t              cfg,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [7:0]        wr_data,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    output step_t             step
);

    localparam int CMP_W = (PTR_W > 7) ? PTR_W : 7;

    logic [PTR_W-1:0] fill_reg;
    logic [PTR_W-1:0] fill_next;
    logic [PTR_W-1:0] msg_len_reg;
    logic [PTR_W-1:0] msg_len_next;
    logic [23:0]      recent_reg;
    logic [23:0]      recent_next;
    logic             marker_reg;
    logic             marker_next;
    logic             addr_found_reg;
    logic             addr_found_next;
    logic             line_bank_reg;
    logic             line_bank_next;

    logic             is_rx;
    logic             is_lf;
    logic             printable;
    logic             room;
    logic             keep;
    logic             take;
    logic             lf_take;
    logic [31:0]      win;
    logic [CMP_W-1:0] idx_w;
    logic [CMP_W-1:0] len_w;
    logic [CMP_W-1:0] len_next_w;
    logic [PTR_W-1:0] idx_p;

    assign is_rx     = (item.mode == MODE_RX);
    assign is_lf     = (item.rx_byte == CH_LF);
    assign printable = (item.rx_byte >= CH_FIRST_PRINT) && (item.rx_byte <= CH_LAST_PRINT);
    assign room      = (fill_reg < PTR_W'(LINE_DEPTH - 1));
    assign keep      = is_rx && printable && room;
    assign take      = cfg.filter_enable
                     ? (marker_reg && (!cfg.address_filter_enable || addr_found_reg))
                     : (fill_reg != '0);
    assign lf_take   = is_rx && is_lf && take;
    assign win       = {recent_reg, item.rx_byte};

    assign idx_w = CMP_W'(item.read_index);
    assign len_w = CMP_W'(msg_len_reg);
    assign idx_p = idx_w[PTR_W-1:0];

    always_comb
    begin
        fill_next       = fill_reg;
        recent_next     = recent_reg;
        marker_next     = marker_reg;
        addr_found_next = addr_found_reg;
        msg_len_next    = msg_len_reg;
        line_bank_next  = line_bank_reg;
        if (is_rx && is_lf)
        begin
            fill_next       = '0;
            recent_next     = '0;
            marker_next     = 1'b0;
            addr_found_next = 1'b0;
            if (take)
            begin
                msg_len_next   = fill_reg;
                line_bank_next = !line_bank_reg;
            end
        end
        else if (keep)
        begin
            fill_next   = fill_reg + PTR_W'(1);
            recent_next = win[23:0];
            if (win == MARKER_WORD)
            begin
                marker_next = 1'b1;
            end
            if (win == address_word(cfg.target_address))
            begin
                addr_found_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            recent_reg     <= '0;
            marker_reg     <= 1'b0;
            addr_found_reg <= 1'b0;
            msg_len_reg    <= '0;
            line_bank_reg  <= 1'b0;
        end
        else if (step_en)
        begin
            fill_reg       <= fill_next;
            recent_reg     <= recent_next;
            marker_reg     <= marker_next;
            addr_found_reg <= addr_found_next;
            msg_len_reg    <= msg_len_next;
            line_bank_reg  <= line_bank_next;
        end
    end

    assign wr_en   = step_en && keep;
    assign wr_addr = line_bank_reg ? (ADDR_W'(fill_reg) + ADDR_W'(LINE_DEPTH))
                                   : ADDR_W'(fill_reg);
    assign wr_data = item.rx_byte;

    assign step.hit      = (item.mode == MODE_READ) && (idx_w < len_w);
    assign rd_en         = step_en && step.hit;
    assign rd_addr       = line_bank_reg ? ADDR_W'(idx_p)
                                         : (ADDR_W'(idx_p) + ADDR_W'(LINE_DEPTH));
    assign step.accepted = lf_take;
    assign len_next_w    = CMP_W'(msg_len_next);
    assign step.length   = len_next_w[6:0];

endmodule

FILE: hdl/slkf_checker.sv
// ============================================================================
// slkf_checker
// Port-level checks for the serial line keyword filter, bound to the top
// level.
// ============================================================================
module slkf_checker
    import slkf_pkg::*;
#(
    parameter int LINE_DEPTH = DEFAULT_LINE_DEPTH
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  req_stall,
    input logic                  rsp_valid,
    input logic                  rsp_stall,
    input rsp_item_t             rsp
);

    // The output stage holds a stalled item unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed or vanished");

    // The input only stalls when a result is waiting at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid && rsp_stall)
        else $error("input stalled without a waiting result");

    // An accepted line comes from a received byte, which reads no data.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.line_accepted |-> rsp.read_data == 8'd0)
        else $error("accepted line carries read data");

    // The stored length never reaches the buffer depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (LINE_DEPTH > 128) || (int'(rsp.line_length) < LINE_DEPTH))
        else $error("line length out of range");

endmodule

bind serial_line_keyword_filter slkf_checker #(
    .LINE_DEPTH (LINE_DEPTH)
) u_slkf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Checks the serial line keyword filter item by item. A directed table covers
// the byte classes, empty and short lines and read back at and beyond the
// stored length. Random phases then feed lines with and without the marker
// and the address text, noise bytes and overlong lines under several filter
// settings. Table rows marked for a check carry their own expected result; an in-bench predictor supplies the rest.
// ============================================================================
module tb_top;
    import slkf_pkg::*;

    localparam int          DEPTH       = DEFAULT_LINE_DEPTH;
    localparam int          LIMIT       = 1000000;
    localparam int          PHASE_ITEMS = 120;
    localparam int          N_PHASES    = 8;
    localparam int          N_DIR       = 23;
    localparam logic [1:0]  REG_UNUSED  = 2'd3;
    localparam logic [7:0]  CH_NINE     = "9";
    localparam logic [7:0]  ASCII_ZERO  = "0";
    localparam logic [7:0]  ASCII_A     = "A";

    typedef struct packed {
        req_item_t stim;
        logic      chk;
        rsp_item_t want;
    } dir_row_t;

    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        {MODE_READ, 8'hA5,          7'd0,   1'b1, 1'b0, 7'd0, 8'h00},
        {MODE_READ, 8'h5A,          7'd127, 1'b1, 1'b0, 7'd0, 8'h00},
        {MODE_RX,   CH_LF,          7'd0,   1'b1, 1'b0, 7'd0, 8'h00},
        {MODE_RX,   CH_CR,          7'd127, 1'b1, 1'b0, 7'd0, 8'h00},
        {MODE_RX,   8'h00,          7'd85,  1'b1, 1'b0, 7'd0, 8'h00},
        {MODE_RX,   8'hFF,          7'd42,  1'b1, 1'b0, 7'd0, 8'h00},
        {MODE_RX,   8'h7F,          7'd0,   1'b1, 1'b0, 7'd0, 8'h00},
        {MODE_RX,   8'h1F,          7'd0,   1'b1, 1'b0, 7'd0, 8'h00},
        {MODE_RX,   CH_FIRST_PRINT, 7'd0,   1'b1, 1'b0, 7'd0, 8'h00},
        {MODE_RX,   CH_LAST_PRINT,  7'd0,   1'b1, 1'b0, 7'd0, 8'h00},
        {MODE_RX,   CH_CR,          7'd0,   1'b1, 1'b0, 7'd0, 8'h00},
        {MODE_RX,   CH_LF,          7'd0,   1'b1, 1'b1, 7'd2, 8'h00},
        {MODE_READ, 8'h00,          7'd0,   1'b1, 1'b0, 7'd2, CH_FIRST_PRINT},
        {MODE_READ, 8'hFF,          7'd1,   1'b1, 1'b0, 7'd2, CH_LAST_PRINT},
        {MODE_READ, CH_LF,          7'd2,   1'b1, 1'b0, 7'd2, 8'h00},
        {MODE_READ, 8'h00,          7'd99,  1'b1, 1'b0, 7'd2, 8'h00},
        {MODE_RX,   CH_NINE,        7'd0,   1'b0, 1'b0, 7'd0, 8'h00},
        {MODE_RX,   CH_NINE,        7'd0,   1'b0, 1'b0, 7'd0, 8'h00},
        {MODE_RX,   CH_NINE,        7'd0,   1'b0, 1'b0, 7'd0, 8'h00},
        {MODE_RX,   CH_NINE,        7'd0,   1'b0, 1'b0, 7'd0, 8'h00},
        {MODE_RX,   CH_LF,          7'd0,   1'b1, 1'b1, 7'd4, 8'h00},
        {MODE_READ, 8'h00,          7'd3,   1'b0, 1'b0, 7'd0, 8'h00},
        {MODE_RX,   CH_LF,          7'd0,   1'b1, 1'b0, 7'd4, 8'h00}
    };

    // Phases four and up get a random target address.
    localparam cfg_t PHASE_CFG [N_PHASES] = '{
        {1'b1, 1'b0, 16'h0000},
        {1'b1, 1'b1, 16'h0000},
        {1'b1, 1'b1, 16'hFFFF},
        {1'b1, 1'b1, 16'h9999},
        {1'b1, 1'b1, 16'h0000},
        {1'b0, 1'b1, 16'h0000},
        {1'b1, 1'b1, 16'h0000},
        {1'b0, 1'b0, 16'h0000}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_stall;
    req_item_t             req;
    logic                  rsp_valid;
    logic                  rsp_stall;
    rsp_item_t             rsp;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    cfg_t       cfg_now;
    logic [7:0] line_buf [DEPTH];
    logic [7:0] msg_buf [DEPTH];
    int         fill;
    int         msg_len;
    logic [23:0] tail;
    logic       marker_hit;
    logic       addr_hit;

    rsp_item_t  pending_rsp [$];
    logic [7:0] line_bytes [$];
    rsp_item_t  want;
    int         mismatches;
    bit         gaps_on;
    int         stall_left;

    serial_line_keyword_filter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (LIMIT) @(posedge clk);
        $display("tb_top: errors");
        $finish;
    end

    function automatic logic [7:0] ascii_nibble(input logic [3:0] n);
        return (n < 4'd10) ? ASCII_ZERO + 8'(n) : ASCII_A + 8'(n) - 8'd10;
    endfunction

    function automatic logic [31:0] address_text(input logic [15:0] a);
        return {ascii_nibble(a[15:12]), ascii_nibble(a[11:8]),
                ascii_nibble(a[7:4]), ascii_nibble(a[3:0])};
    endfunction

    function automatic rsp_item_t filter_predict(input req_item_t it);
        rsp_item_t   r;
        logic [31:0] win;
        logic        take;
        r = '0;
        if (it.mode == MODE_READ)
        begin
            if (int'(it.read_index) < msg_len)
            begin
                r.read_data = msg_buf[it.read_index];
            end
        end
        else if (it.rx_byte == CH_LF)
        begin
            if (cfg_now.filter_enable)
            begin
                take = marker_hit && (!cfg_now.address_filter_enable || addr_hit);
            end
            else
            begin
                take = (fill != 0);
            end
            if (take)
            begin
                for (int i = 0; i < fill; i++)
                begin
                    msg_buf[i] = line_buf[i];
                end
                msg_len = fill;
                r.line_accepted = 1'b1;
            end
            fill = 0;
            tail = '0;
            marker_hit = 1'b0;
            addr_hit = 1'b0;
        end
        else if (it.rx_byte >= CH_FIRST_PRINT && it.rx_byte <= CH_LAST_PRINT
                 && fill < DEPTH - 1)
        begin
            win = {tail, it.rx_byte};
            line_buf[fill] = it.rx_byte;
            fill++;
            if (win == MARKER_WORD)
            begin
                marker_hit = 1'b1;
            end
            if (win == address_text(cfg_now.target_address))
            begin
                addr_hit = 1'b1;
            end
            tail = win[23:0];
        end
        r.line_length = 7'(msg_len);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(input req_item_t it, input logic chk, input rsp_item_t fixed);
        int        gap;
        rsp_item_t p;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= it;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        p = filter_predict(it);
        pending_rsp.push_back(chk ? fixed : p);
    endtask

    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        case (idx)
            REG_FILTER_ENABLE:  cfg_now.filter_enable = data[0];
            REG_ADDRESS_ENABLE: cfg_now.address_filter_enable = data[0];
            REG_TARGET_ADDRESS: cfg_now.target_address = data[15:0];
            default: ;
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic push_text(input logic [31:0] w, input int cnt);
        for (int k = 3; k >= 4 - cnt; k--)
        begin
            line_bytes.push_back(w[8*k +: 8]);
        end
    endtask

    task automatic build_line();
        int          n;
        int          mpos;
        int          apos;
        bit          mk;
        bit          ad;
        logic [15:0] who;
        logic [7:0]  c;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(95, 130) : $urandom_range(0, 14);
        mk = ($urandom_range(0, 9) < 6);
        ad = ($urandom_range(0, 9) < 6);
        mpos = $urandom_range(0, n);
        apos = $urandom_range(0, n);
        who = ($urandom_range(0, 9) < 7) ? cfg_now.target_address : 16'($urandom);
        for (int i = 0; i <= n; i++)
        begin
            if (mk && i == mpos)
            begin
                push_text(MARKER_WORD, ($urandom_range(0, 4) == 0) ? 3 : 4);
            end
            if (ad && i == apos)
            begin
                push_text(address_text(who), 4);
            end
            if (i < n)
            begin
                if ($urandom_range(0, 11) == 0)
                begin
                    case ($urandom_range(0, 2))
                        0:       c = CH_CR;
                        1:       c = 8'($urandom_range(0, 31));
                        default: c = 8'($urandom_range(127, 255));
                    endcase
                end
                else if ($urandom_range(0, 1) == 0)
                begin
                    c = ascii_nibble(4'($urandom));
                end
                else
                begin
                    c = 8'($urandom_range(CH_FIRST_PRINT, CH_LAST_PRINT));
                end
                line_bytes.push_back(c);
            end
        end
        line_bytes.push_back(CH_LF);
    endtask

    initial
    begin
        rsp_stall = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                rsp_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                rsp_stall <= 1'b0;
                if ($urandom_range(0, 9) < 3)
                begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: unexpected result acc=%0d len=%0d data=%h",
                         $time, rsp.line_accepted, rsp.line_length, rsp.read_data);
                mismatches++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.line_accepted !== want.line_accepted
                    || rsp.line_length !== want.line_length
                    || rsp.read_data !== want.read_data)
                begin
                    $display("%0t: expected acc=%0d len=%0d data=%h, got acc=%0d len=%0d data=%h",
                             $time, want.line_accepted, want.line_length, want.read_data,
                             rsp.line_accepted, rsp.line_length, rsp.read_data);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        req_item_t it;
        cfg_t      pc;
        int        counted;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        gaps_on = 1'b1;
        cfg_now = {1'b0, 1'b0, TARGET_ADDRESS_RESET};
        fill = 0;
        msg_len = 0;
        tail = '0;
        marker_hit = 1'b0;
        addr_hit = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIR; i++)
        begin
            send_item(DIR_ROWS[i].stim, DIR_ROWS[i].chk, DIR_ROWS[i].want);
        end
        drain();

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            pc = PHASE_CFG[ph];
            if (ph >= 4)
            begin
                pc.target_address = 16'($urandom);
            end
            apb_write(REG_FILTER_ENABLE, {31'($urandom), pc.filter_enable});
            apb_write(REG_ADDRESS_ENABLE, {31'($urandom), pc.address_filter_enable});
            apb_write(REG_TARGET_ADDRESS, {16'($urandom), pc.target_address});
            if (ph == 0)
            begin
                apb_write(REG_UNUSED, $urandom);
            end
            gaps_on = (ph % 3 != 2);
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                it.read_index = 7'($urandom_range(0, 127));
                it.rx_byte = 8'($urandom);
                if ($urandom_range(0, 99) < 12)
                begin
                    it.mode = MODE_READ;
                    if ($urandom_range(0, 3) != 0)
                    begin
                        it.read_index = 7'($urandom_range(0, msg_len));
                    end
                end
                else
                begin
                    it.mode = MODE_RX;
                    if (line_bytes.size() == 0)
                    begin
                        build_line();
                    end
                    it.rx_byte = line_bytes.pop_front();
                end
                send_item(it, 1'b0, '0);
                if (it.mode == MODE_READ || it.rx_byte == CH_LF
                    || (it.rx_byte >= CH_FIRST_PRINT && it.rx_byte <= CH_LAST_PRINT))
                begin
                    counted++;
                end
            end
            drain();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("tb_top: clean");
        end
        else
        begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
